// ===== rtl/nbm_pkg.sv =====
// Shared types and constants for the nibble bank mapper.
package nbm_pkg;

   localparam int unsigned SLOT_COUNT = 11;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned BANK_W     = 8;
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned NIB_W      = 4;
   localparam int unsigned LINE_W     = 16;
   localparam int unsigned COUNT_W    = 9;

   localparam logic [LINE_W-1:0] LINE_STEP = LINE_W'(113);

   localparam logic [SLOT_W-1:0] SLOT_PRG_LAST  = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_CHR_FIRST = SLOT_W'(3);

   localparam logic [3:0] PAGE_PRG0 = 4'h8;
   localparam logic [3:0] PAGE_PRG2 = 4'h9;
   localparam logic [3:0] PAGE_CHRA = 4'hA;
   localparam logic [3:0] PAGE_CHRB = 4'hB;
   localparam logic [3:0] PAGE_CHRC = 4'hC;
   localparam logic [3:0] PAGE_CHRD = 4'hD;
   localparam logic [3:0] PAGE_IRQ  = 4'hE;
   localparam logic [3:0] PAGE_CTRL = 4'hF;

   localparam logic [1:0] CTRL_RELOAD = 2'd0;
   localparam logic [1:0] CTRL_ENABLE = 2'd1;
   localparam logic [1:0] CTRL_MIRROR = 2'd2;

   typedef enum logic [1:0] {
      LAYOUT_HORIZONTAL = 2'd0,
      LAYOUT_VERTICAL   = 2'd1,
      LAYOUT_SINGLE     = 2'd2
   } layout_type;

   typedef struct packed {
      logic              is_bank;
      logic [SLOT_W-1:0] slot;
      logic              high;
      logic              is_latch;
      logic [1:0]        latch_nib;
      logic              is_reload;
      logic              is_enable;
      logic              is_mirror;
   } dec_type;

   typedef struct packed {
      logic              bank_written;
      logic [SLOT_W-1:0] bank_slot;
      logic [BANK_W-1:0] bank_value;
      logic              mirroring_written;
      logic [1:0]        mirroring_layout;
      logic              irq_request;
   } rsp_type;

endpackage

// ===== rtl/nibble_bank_mapper_with_irq_top.sv =====
// Top level of the nibble bank mapper with scanline IRQ counter.
// Each transfer is a CPU register write or a scanline tick and yields exactly one result.
// An item is captured in an input register, decoded and applied to the mapper state as it
// moves on, and its result is held in an output register until taken; one item is taken
// every cycle while the result side keeps up. A write to the bank count reloads slots 2
// and 3 with the last two program bank numbers and must only occur while no transfer is
// in flight.
module nibble_bank_mapper_with_irq_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [nbm_pkg::ADDR_W-1:0]     req_address,
   input  logic [nbm_pkg::DATA_W-1:0]     req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_bank_written,
   output logic [nbm_pkg::SLOT_W-1:0]     rsp_bank_slot,
   output logic [nbm_pkg::BANK_W-1:0]     rsp_bank_value,
   output logic                           rsp_mirroring_written,
   output logic [1:0]                     rsp_mirroring_layout,
   output logic                           rsp_irq_request,
   input  logic                           csr_wr_en,
   input  logic [nbm_pkg::COUNT_W-1:0]    csr_wr_data
);
   import nbm_pkg::*;

   logic              in_valid_ff;
   logic              in_mode_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;
   logic              advance;
   dec_type           dec;
   rsp_type           result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   nbm_decode u_decode (
      .address (in_addr_ff),
      .dec     (dec)
   );

   nbm_state u_state (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .mode      (in_mode_ff),
      .dec       (dec),
      .nib       (in_data_ff[NIB_W-1:0]),
      .csr_wr_en (csr_wr_en),
      .csr_count (csr_wr_data[BANK_W-1:0]),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_addr_ff <= req_address;
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_bank_written      = out_ff.bank_written;
   assign rsp_bank_slot         = out_ff.bank_slot;
   assign rsp_bank_value        = out_ff.bank_value;
   assign rsp_mirroring_written = out_ff.mirroring_written;
   assign rsp_mirroring_layout  = out_ff.mirroring_layout;
   assign rsp_irq_request       = out_ff.irq_request;

endmodule

// ===== rtl/nbm_decode.sv =====
// Address decoder for CPU writes to the mapper registers.
module nbm_decode (
   input  logic [nbm_pkg::ADDR_W-1:0] address,
   output nbm_pkg::dec_type           dec
);
   import nbm_pkg::*;

   logic [3:0] page;
   logic       low_zero;

   assign page     = address[15:12];
   assign low_zero = (address[11:2] == '0);

   always_comb begin
      dec = '0;
      dec.high = address[0];
      dec.latch_nib = address[1:0];
      case (page)
         PAGE_PRG0: begin
            dec.is_bank = low_zero;
            dec.slot    = SLOT_W'(address[1]);
         end
         PAGE_PRG2: begin
            dec.is_bank = low_zero && !address[1];
            dec.slot    = SLOT_PRG_LAST;
         end
         PAGE_CHRA: begin
            dec.is_bank = low_zero;
            dec.slot    = SLOT_CHR_FIRST + SLOT_W'(address[1]);
         end
         PAGE_CHRB: begin
            dec.is_bank = low_zero;
            dec.slot    = SLOT_CHR_FIRST + SLOT_W'(2) + SLOT_W'(address[1]);
         end
         PAGE_CHRC: begin
            dec.is_bank = low_zero;
            dec.slot    = SLOT_CHR_FIRST + SLOT_W'(4) + SLOT_W'(address[1]);
         end
         PAGE_CHRD: begin
            dec.is_bank = low_zero;
            dec.slot    = SLOT_CHR_FIRST + SLOT_W'(6) + SLOT_W'(address[1]);
         end
         PAGE_IRQ: begin
            dec.is_latch = low_zero;
         end
         PAGE_CTRL: begin
            dec.is_reload = low_zero && (address[1:0] == CTRL_RELOAD);
            dec.is_enable = low_zero && (address[1:0] == CTRL_ENABLE);
            dec.is_mirror = low_zero && (address[1:0] == CTRL_MIRROR);
         end
         default: begin
            dec = '0;
         end
      endcase
   end

endmodule

// ===== rtl/nbm_state.sv =====
// Mapper state: bank registers, IRQ latch and counter, and the result logic.
module nbm_state (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        mode,
   input  nbm_pkg::dec_type            dec,
   input  logic [nbm_pkg::NIB_W-1:0]   nib,
   input  logic                        csr_wr_en,
   input  logic [nbm_pkg::BANK_W-1:0]  csr_count,
   output nbm_pkg::rsp_type            result
);
   import nbm_pkg::*;

   logic [BANK_W-1:0] bank_ff [SLOT_COUNT];
   logic [BANK_W-1:0] bank_in [SLOT_COUNT];
   logic [LINE_W-1:0] reload_ff, reload_in;
   logic [LINE_W-1:0] counter_ff, counter_in;
   logic              enable_ff, enable_in;
   logic [BANK_W-1:0] cur_bank;
   logic [BANK_W-1:0] new_bank;
   logic [1:0]        code;

   assign cur_bank = bank_ff[dec.slot];
   assign new_bank = dec.high ? {nib, cur_bank[NIB_W-1:0]} : {cur_bank[BANK_W-1:NIB_W], nib};
   assign code     = nib[1:0];

   always_comb begin
      result = '0;
      if (mode) begin
         result.irq_request = enable_ff && (counter_ff <= LINE_STEP);
      end else if (dec.is_bank) begin
         result.bank_written = 1'b1;
         result.bank_slot    = dec.slot;
         result.bank_value   = new_bank;
      end else if (dec.is_mirror) begin
         result.mirroring_written = 1'b1;
         case (code)
            2'd0:    result.mirroring_layout = LAYOUT_HORIZONTAL;
            2'd1:    result.mirroring_layout = LAYOUT_VERTICAL;
            default: result.mirroring_layout = LAYOUT_SINGLE;
         endcase
      end
   end

   always_comb begin
      bank_in    = bank_ff;
      reload_in  = reload_ff;
      counter_in = counter_ff;
      enable_in  = enable_ff;
      if (advance) begin
         if (mode) begin
            if (enable_ff) begin
               if (counter_ff <= LINE_STEP) begin
                  counter_in = '0;
                  enable_in  = 1'b0;
               end else begin
                  counter_in = counter_ff - LINE_STEP;
               end
            end
         end else if (dec.is_bank) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (dec.slot == SLOT_W'(i)) begin
                  bank_in[i] = new_bank;
               end
            end
         end else if (dec.is_latch) begin
            reload_in[{dec.latch_nib, 2'b00} +: NIB_W] = nib;
         end else if (dec.is_reload) begin
            counter_in = reload_ff;
         end else if (dec.is_enable) begin
            enable_in = nib[0];
         end
      end
      if (csr_wr_en) begin
         bank_in[SLOT_PRG_LAST]  = csr_count - BANK_W'(2);
         bank_in[SLOT_CHR_FIRST] = csr_count - BANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (SLOT_W'(i) == SLOT_PRG_LAST) begin
               bank_ff[i] <= BANK_W'(254);
            end else if (SLOT_W'(i) == SLOT_CHR_FIRST) begin
               bank_ff[i] <= BANK_W'(255);
            end else if (i == 1) begin
               bank_ff[i] <= BANK_W'(1);
            end else begin
               bank_ff[i] <= '0;
            end
         end
         reload_ff  <= '0;
         counter_ff <= '0;
         enable_ff  <= 1'b0;
      end else begin
         bank_ff    <= bank_in;
         reload_ff  <= reload_in;
         counter_ff <= counter_in;
         enable_ff  <= enable_in;
      end
   end

endmodule

// ===== rtl/nbm_checker.sv =====
// Port-level checker for the nibble bank mapper, bound to the top level.
module nbm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_bank_written,
   input logic [nbm_pkg::SLOT_W-1:0]   rsp_bank_slot,
   input logic [nbm_pkg::BANK_W-1:0]   rsp_bank_value,
   input logic                         rsp_mirroring_written,
   input logic [1:0]                   rsp_mirroring_layout,
   input logic                         rsp_irq_request
);
   import nbm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bank_value)
         && $stable(rsp_bank_slot) && $stable(rsp_irq_request))
      else $error("result changed while stalled");

   a_bank_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bank_written |-> rsp_bank_slot == '0 && rsp_bank_value == '0)
      else $error("bank fields set without a bank write");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bank_written |-> rsp_bank_slot < SLOT_W'(SLOT_COUNT))
      else $error("bank slot out of range");

   a_layout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mirroring_layout != 2'd3
         && (rsp_mirroring_written || rsp_mirroring_layout == 2'd0))
      else $error("bad mirroring layout");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_request |-> !rsp_bank_written && !rsp_mirroring_written)
      else $error("irq raised on a register write");

endmodule

bind nibble_bank_mapper_with_irq_top nbm_checker u_nbm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_bank_written      (rsp_bank_written),
   .rsp_bank_slot         (rsp_bank_slot),
   .rsp_bank_value        (rsp_bank_value),
   .rsp_mirroring_written (rsp_mirroring_written),
   .rsp_mirroring_layout  (rsp_mirroring_layout),
   .rsp_irq_request       (rsp_irq_request)
);

// ===== tb/sv/nibble_bank_mapper_with_irq_top_tb.sv =====
// Self-checking testbench for the nibble bank mapper with scanline IRQ counter.
`timescale 1ns / 1ps

module nibble_bank_mapper_with_irq_top_tb;
   import nbm_pkg::*;

   localparam int RUN_LIMIT    = 200000;
   localparam int PHASE_ITEMS  = 130;
   localparam int HOLD_AT      = 650;
   localparam int HOLD_CYCLES  = 60;
   localparam int IDLE_PERCENT = 14;
   localparam int PROBE_COUNT  = 25;

   localparam logic [ADDR_W-1:0] SLOT_BASE [SLOT_COUNT] = '{
      16'h8000, 16'h8002, 16'h9000, 16'hA000, 16'hA002, 16'hB000,
      16'hB002, 16'hC000, 16'hC002, 16'hD000, 16'hD002
   };
   localparam logic [ADDR_W-1:0] ADDR_LATCH  = 16'hE000;
   localparam logic [ADDR_W-1:0] ADDR_RELOAD = 16'hF000;
   localparam logic [ADDR_W-1:0] ADDR_ENABLE = 16'hF001;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR = 16'hF002;

   localparam rsp_type NO_EFFECT  = '0;
   localparam rsp_type IRQ_RAISED = '{irq_request: 1'b1, default: '0};

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              fixed;
      rsp_type           rsp;
   } probe_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [DATA_W-1:0]   req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_bank_written;
   logic [SLOT_W-1:0]   rsp_bank_slot;
   logic [BANK_W-1:0]   rsp_bank_value;
   logic                rsp_mirroring_written;
   logic [1:0]          rsp_mirroring_layout;
   logic                rsp_irq_request;
   logic                csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;

   logic                offer_fixed = 1'b0;
   rsp_type             offer_rsp = '0;
   rsp_type             mapper_results_q [$];
   int                  items_sent = 0;
   int                  mismatches = 0;
   int                  cycles = 0;
   logic                quiet_span;

   logic [BANK_W-1:0]   banks [SLOT_COUNT];
   logic [LINE_W-1:0]   latch;
   logic [LINE_W-1:0]   lines;
   logic                irq_on;

   assign quiet_span = (items_sent >= 300) && (items_sent < 500);

   nibble_bank_mapper_with_irq_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_address           (req_address),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bank_written      (rsp_bank_written),
      .rsp_bank_slot         (rsp_bank_slot),
      .rsp_bank_value        (rsp_bank_value),
      .rsp_mirroring_written (rsp_mirroring_written),
      .rsp_mirroring_layout  (rsp_mirroring_layout),
      .rsp_irq_request       (rsp_irq_request),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type bank_rsp(logic [SLOT_W-1:0] slot, logic [BANK_W-1:0] value);
      rsp_type r;
      r = '0;
      r.bank_written = 1'b1;
      r.bank_slot = slot;
      r.bank_value = value;
      return r;
   endfunction

   function automatic rsp_type mirror_rsp(layout_type layout);
      rsp_type r;
      r = '0;
      r.mirroring_written = 1'b1;
      r.mirroring_layout = layout;
      return r;
   endfunction

   function automatic void load_bank_count(logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] second_last;
      logic [COUNT_W-1:0] last;
      second_last = count - COUNT_W'(2);
      last = count - COUNT_W'(1);
      banks[2] = second_last[BANK_W-1:0];
      banks[3] = last[BANK_W-1:0];
   endfunction

   function automatic rsp_type mapper_apply(logic mode, logic [ADDR_W-1:0] addr,
                                            logic [DATA_W-1:0] data);
      rsp_type r;
      logic [NIB_W-1:0] nib;
      r = '0;
      nib = data[NIB_W-1:0];
      if (mode) begin
         if (irq_on) begin
            if (lines <= LINE_STEP) begin
               lines = '0;
               irq_on = 1'b0;
               r.irq_request = 1'b1;
            end else begin
               lines = lines - LINE_STEP;
            end
         end
         return r;
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (addr[ADDR_W-1:1] == SLOT_BASE[s][ADDR_W-1:1]) begin
            if (addr[0]) banks[s][7:4] = nib;
            else banks[s][3:0] = nib;
            r.bank_written = 1'b1;
            r.bank_slot = SLOT_W'(s);
            r.bank_value = banks[s];
            return r;
         end
      end
      if (addr[ADDR_W-1:2] == ADDR_LATCH[ADDR_W-1:2]) begin
         latch[{addr[1:0], 2'b00} +: NIB_W] = nib;
      end else if (addr == ADDR_RELOAD) begin
         lines = latch;
      end else if (addr == ADDR_ENABLE) begin
         irq_on = nib[0];
      end else if (addr == ADDR_MIRROR) begin
         r.mirroring_written = 1'b1;
         if (nib[1:0] == LAYOUT_HORIZONTAL) r.mirroring_layout = LAYOUT_HORIZONTAL;
         else if (nib[1:0] == LAYOUT_VERTICAL) r.mirroring_layout = LAYOUT_VERTICAL;
         else r.mirroring_layout = LAYOUT_SINGLE;
      end
      return r;
   endfunction

   task automatic offer_item(input logic mode, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic fixed,
                             input rsp_type rsp);
      while (!quiet_span && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= addr;
      req_data <= data;
      offer_fixed <= fixed;
      offer_rsp <= rsp;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
   endtask

   task automatic pick_bus_item(output logic mode, output logic [ADDR_W-1:0] addr,
                                output logic [DATA_W-1:0] data);
      int unsigned roll;
      roll = $urandom_range(99);
      mode = 1'b0;
      addr = ADDR_W'($urandom);
      data = DATA_W'($urandom);
      if (roll < 35) begin
         mode = 1'b1;
      end else if (roll < 65) begin
         addr = SLOT_BASE[$urandom_range(SLOT_COUNT - 1)] | ADDR_W'($urandom_range(1));
      end else if (roll < 75) begin
         addr = ADDR_LATCH | ADDR_W'($urandom_range(3));
         if (addr[1] && $urandom_range(7) != 0) data[3:1] = '0;
      end else if (roll < 80) begin
         addr = ADDR_RELOAD;
      end else if (roll < 85) begin
         addr = ADDR_ENABLE;
         data[0] = ($urandom_range(3) != 0);
      end else if (roll < 90) begin
         addr = ADDR_MIRROR;
      end else if (roll < 95) begin
         addr = SLOT_BASE[$urandom_range(SLOT_COUNT - 1)] ^ (ADDR_W'(1) << $urandom_range(15, 1));
      end
   endtask

   task automatic drain_mapper();
      req_valid <= 1'b0;
      do @(posedge clock); while (mapper_results_q.size() != 0);
   endtask

   task automatic set_bank_count(input logic [COUNT_W-1:0] count);
      drain_mapper();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      load_bank_count(count);
   endtask

   // receiver: random stalls, one long hold-off once the sender is well under way
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_span || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("nibble_bank_mapper_with_irq_top_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin : watch_transfers
      rsp_type seen;
      rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            seen = {rsp_bank_written, rsp_bank_slot, rsp_bank_value,
                    rsp_mirroring_written, rsp_mirroring_layout, rsp_irq_request};
            if (mapper_results_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result transfer: bank %b/%0d/%h mirror %b/%0d irq %b",
                           seen.bank_written, seen.bank_slot, seen.bank_value,
                           seen.mirroring_written, seen.mirroring_layout, seen.irq_request);
               mismatches++;
            end else begin
               want = mapper_results_q.pop_front();
               if (seen.bank_written !== want.bank_written ||
                   seen.bank_slot !== want.bank_slot ||
                   seen.bank_value !== want.bank_value ||
                   seen.mirroring_written !== want.mirroring_written ||
                   seen.mirroring_layout !== want.mirroring_layout ||
                   seen.irq_request !== want.irq_request) begin
                  if (mismatches < 10)
                     $display({"mismatch: expected bank %b/%0d/%h mirror %b/%0d irq %b, ",
                               "actual bank %b/%0d/%h mirror %b/%0d irq %b"},
                              want.bank_written, want.bank_slot, want.bank_value,
                              want.mirroring_written, want.mirroring_layout, want.irq_request,
                              seen.bank_written, seen.bank_slot, seen.bank_value,
                              seen.mirroring_written, seen.mirroring_layout, seen.irq_request);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            want = mapper_apply(req_mode, req_address, req_data);
            if (offer_fixed) want = offer_rsp;
            mapper_results_q.push_back(want);
         end
      end
   end

   initial begin
      probe_type          probes [PROBE_COUNT];
      logic               mode;
      logic [ADDR_W-1:0]  addr;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] counts [7];

      for (int s = 0; s < SLOT_COUNT; s++) banks[s] = '0;
      banks[1] = 8'd1;
      load_bank_count(COUNT_W'(256));
      latch = '0;
      lines = '0;
      irq_on = 1'b0;

      probes = '{
         '{1'b1, 16'h8001, 8'hFF, 1'b1, NO_EFFECT},
         '{1'b0, 16'h8000, 8'hFF, 1'b1, bank_rsp(4'd0, 8'h0F)},
         '{1'b0, 16'h8001, 8'hA5, 1'b1, bank_rsp(4'd0, 8'h5F)},
         '{1'b0, 16'h8002, 8'hF0, 1'b1, bank_rsp(4'd1, 8'h00)},
         '{1'b0, 16'h9000, 8'h07, 1'b0, NO_EFFECT},
         '{1'b0, 16'h9001, 8'h03, 1'b0, NO_EFFECT},
         '{1'b0, 16'hA001, 8'h0C, 1'b0, NO_EFFECT},
         '{1'b0, 16'hD003, 8'hFF, 1'b1, bank_rsp(4'd10, 8'hF0)},
         '{1'b0, 16'hD002, 8'h00, 1'b1, bank_rsp(4'd10, 8'hF0)},
         '{1'b0, 16'hF002, 8'h00, 1'b1, mirror_rsp(LAYOUT_HORIZONTAL)},
         '{1'b0, 16'hF002, 8'hFD, 1'b1, mirror_rsp(LAYOUT_VERTICAL)},
         '{1'b0, 16'hF002, 8'h02, 1'b1, mirror_rsp(LAYOUT_SINGLE)},
         '{1'b0, 16'hF002, 8'hFF, 1'b1, mirror_rsp(LAYOUT_SINGLE)},
         '{1'b0, 16'hFFFF, 8'hFF, 1'b1, NO_EFFECT},
         '{1'b0, 16'h0000, 8'h00, 1'b1, NO_EFFECT},
         '{1'b0, 16'hE000, 8'hF4, 1'b0, NO_EFFECT},
         '{1'b0, 16'hE001, 8'h0E, 1'b0, NO_EFFECT},
         '{1'b0, 16'hE002, 8'h00, 1'b0, NO_EFFECT},
         '{1'b0, 16'hE003, 8'hF0, 1'b0, NO_EFFECT},
         '{1'b0, 16'hF000, 8'h00, 1'b0, NO_EFFECT},
         '{1'b0, 16'hF001, 8'hFF, 1'b0, NO_EFFECT},
         '{1'b1, 16'h0000, 8'h00, 1'b0, NO_EFFECT},
         '{1'b1, 16'hFFFF, 8'hFF, 1'b0, NO_EFFECT},
         '{1'b1, 16'hF001, 8'h01, 1'b1, IRQ_RAISED},
         '{1'b1, 16'h0000, 8'h00, 1'b1, NO_EFFECT}
      };
      counts = '{COUNT_W'(2), COUNT_W'(0), COUNT_W'(1), COUNT_W'(255),
                 COUNT_W'($urandom_range(254, 3)), COUNT_W'(3), COUNT_W'(256)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i])
         offer_item(probes[i].mode, probes[i].addr, probes[i].data,
                    probes[i].fixed, probes[i].rsp);

      for (int phase = 0; phase <= 7; phase++) begin
         if (phase > 0) set_bank_count(counts[phase - 1]);
         repeat (PHASE_ITEMS) begin
            pick_bus_item(mode, addr, data);
            offer_item(mode, addr, data, 1'b0, NO_EFFECT);
         end
      end

      drain_mapper();
      repeat (8) @(posedge clock);
      mismatches += mapper_results_q.size();
      if (mismatches == 0) begin
         $display("nibble_bank_mapper_with_irq_top_tb passed");
      end else begin
         $display("nibble_bank_mapper_with_irq_top_tb failed");
      end
      $finish;
   end

endmodule
